/* src/rcb_pkg.sv */
`default_nettype none

package rcb_pkg;

    localparam int MAX_WIDTH = 2048;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);

    localparam int CHAN_W    = 8;
    localparam int NUM_CHAN  = 3;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 12;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    // 5*center + four neighbors, at most 9*255
    localparam int SUM_W       = 12;
    // floor(s/9) == (s*7282) >> 16 for every s below 2304
    localparam int RECIP_W     = 13;
    localparam int RECIP_SHIFT = 16;
    localparam logic [RECIP_W-1:0] RECIP_NINTH = 13'd7282;

    localparam logic [CFG_W-1:0] WIDTH_RESET  = 12'd640;
    localparam logic [CFG_W-1:0] HEIGHT_RESET = 12'd480;
    localparam logic [CFG_W-1:0] MIN_DIM      = 12'd3;
    localparam logic [CFG_W-1:0] MAX_DIM      = CFG_W'(MAX_WIDTH);

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef struct packed {
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } rgb_t;

    typedef struct packed {
        rgb_t two_up;
        rgb_t one_up;
    } line_pair_t;

endpackage

`default_nettype wire

/* src/rcb_pix_if.sv */
`default_nettype none

interface rcb_pix_if;
    import rcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_in;
    logic [CHAN_W-1:0] green_in;
    logic [CHAN_W-1:0] blue_in;

    modport source (output valid, output red_in, output green_in, output blue_in,
                    input ready);
    modport sink   (input valid, input red_in, input green_in, input blue_in,
                    output ready);
endinterface

`default_nettype wire

/* src/rcb_res_if.sv */
`default_nettype none

interface rcb_res_if;
    import rcb_pkg::*;

    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red_out;
    logic [CHAN_W-1:0] green_out;
    logic [CHAN_W-1:0] blue_out;
    logic [ROW_W-1:0]  out_row;
    logic [COL_W-1:0]  out_col;
    logic              frame_done;

    modport source (output valid, output red_out, output green_out, output blue_out,
                    output out_row, output out_col, output frame_done, input ready);
    modport sink   (input valid, input red_out, input green_out, input blue_out,
                    input out_row, input out_col, input frame_done, output ready);
endinterface

`default_nettype wire

/* src/rcb_lane.sv */
`default_nettype none

module rcb_lane (
    input  wire                          clk,
    input  wire                          load,
    input  wire  [rcb_pkg::CHAN_W-1:0]   center,
    input  wire  [rcb_pkg::CHAN_W-1:0]   up,
    input  wire  [rcb_pkg::CHAN_W-1:0]   down,
    input  wire  [rcb_pkg::CHAN_W-1:0]   left,
    input  wire  [rcb_pkg::CHAN_W-1:0]   right,
    output logic [rcb_pkg::CHAN_W-1:0]   quot
);
    import rcb_pkg::*;

    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;
    logic [SUM_W+RECIP_W-1:0] prod;

    always_comb
    begin
        sum_next = {2'b00, center, 2'b00} + SUM_W'(center)
                 + SUM_W'(up) + SUM_W'(down) + SUM_W'(left) + SUM_W'(right);
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sum_reg <= sum_next;
        end
    end

    // divide by nine through the reciprocal
    assign prod = (SUM_W+RECIP_W)'(sum_reg) * (SUM_W+RECIP_W)'(RECIP_NINTH);
    assign quot = prod[RECIP_SHIFT +: CHAN_W];

endmodule

`default_nettype wire

/* src/rgb_3x3_cross_blur.sv */
// Streaming 3x3 cross blur, one RGB word per clock unless the output stalls.
// A result follows its completing pixel through stage 1, stage 2, output register.
// One pixel per cycle unless stalled; line buffer read and written once per pixel.
// Reset: row/column counters clear, width 640, height 480; line buffer and
// window are not cleared and need no clearing pass.
`default_nettype none

module rgb_3x3_cross_blur (
    input  wire                            clk,
    input  wire                            rst_n,
    rcb_pix_if.sink                        pixel,
    rcb_res_if.source                      result,
    input  wire                            cfg_wr_en,
    input  wire  [rcb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire  [rcb_pkg::CFG_W-1:0]      cfg_data
);
    import rcb_pkg::*;

    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;
    logic [COL_W-1:0] col_reg;
    logic [ROW_W-1:0] row_reg;

    logic [CFG_W-1:0] width_eff;
    logic [CFG_W-1:0] height_eff;
    logic             last_col;
    logic             last_row;
    logic             emit;
    logic             accept;

    // stage 1: buffer read in flight
    logic             s1_valid_reg;
    logic             s1_emit_reg;
    logic             s1_done_reg;
    rgb_t             s1_px_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [ROW_W-1:0] s1_row_reg;
    logic [COL_W-1:0] s1_col_reg;
    line_pair_t       rd_reg;

    // stage 2: lane sums
    logic             s2_valid_reg;
    logic             s2_done_reg;
    logic [ROW_W-1:0] s2_row_reg;
    logic [COL_W-1:0] s2_col_reg;

    // output register
    logic             res_valid_reg;
    rgb_t             res_px_reg;
    logic             res_done_reg;
    logic [ROW_W-1:0] res_row_reg;
    logic [COL_W-1:0] res_col_reg;

    logic             s1_adv;
    logic             s2_en;
    logic             s3_en;
    logic             lane_load;

    line_pair_t       line_mem [MAX_WIDTH];
    rgb_t             win_reg [6];
    rgb_t             quot;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT: height_reg <= cfg_data;
                default:          width_reg  <= width_reg;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < MIN_DIM)
            width_eff = MIN_DIM;
        else if (width_reg > MAX_DIM)
            width_eff = MAX_DIM;
        else
            width_eff = width_reg;
        height_eff = (height_reg < MIN_DIM) ? MIN_DIM : height_reg;
        last_col   = ({1'b0, col_reg} + CFG_W'(1)) >= width_eff;
        last_row   = ({1'b0, row_reg} + (ROW_W+1)'(1)) >= {1'b0, height_eff};
        emit       = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
    end

    // pipeline flow
    assign s3_en       = !res_valid_reg || result.ready;
    assign s2_en       = !s2_valid_reg || s3_en;
    assign s1_adv      = s1_valid_reg && s2_en;
    assign pixel.ready = !s1_valid_reg || s2_en;
    assign accept      = pixel.valid && pixel.ready;
    assign lane_load   = s1_adv && s1_emit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg       <= '0;
            row_reg       <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                if (last_col)
                begin
                    col_reg <= '0;
                    row_reg <= last_row ? '0 : row_reg + ROW_W'(1);
                end
                else
                begin
                    col_reg <= col_reg + COL_W'(1);
                end
            end
            if (pixel.ready)
                s1_valid_reg <= pixel.valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg && s1_emit_reg;
            if (s3_en)
                res_valid_reg <= s2_valid_reg;
        end
    end

    // stage 1 payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_px_reg   <= '{blue: pixel.blue_in, green: pixel.green_in, red: pixel.red_in};
            s1_addr_reg <= col_reg[ADDR_W-1:0];
            s1_emit_reg <= emit;
            s1_done_reg <= last_col && last_row;
            s1_row_reg  <= row_reg - ROW_W'(1);
            s1_col_reg  <= col_reg - COL_W'(1);
        end
    end

    // line buffer: consecutive words never share a column, so the read and
    // the write of one cycle always hit different entries
    always_ff @(posedge clk)
    begin
        if (s1_adv)
            line_mem[s1_addr_reg] <= '{two_up: rd_reg.one_up, one_up: s1_px_reg};
        if (accept)
            rd_reg <= line_mem[col_reg[ADDR_W-1:0]];
    end

    // window: 0..2 column c-1 top/mid/bottom, 3..5 column c-2
    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            win_reg[3] <= win_reg[0];
            win_reg[4] <= win_reg[1];
            win_reg[5] <= win_reg[2];
            win_reg[0] <= rd_reg.two_up;
            win_reg[1] <= rd_reg.one_up;
            win_reg[2] <= s1_px_reg;
        end
    end

    for (genvar k = 0; k < NUM_CHAN; k++)
    begin : g_lane
        rcb_lane u_lane (
            .clk    (clk),
            .load   (lane_load),
            .center (win_reg[1][k*CHAN_W +: CHAN_W]),
            .up     (win_reg[0][k*CHAN_W +: CHAN_W]),
            .down   (win_reg[2][k*CHAN_W +: CHAN_W]),
            .left   (win_reg[4][k*CHAN_W +: CHAN_W]),
            .right  (rd_reg.one_up[k*CHAN_W +: CHAN_W]),
            .quot   (quot[k*CHAN_W +: CHAN_W])
        );
    end

    always_ff @(posedge clk)
    begin
        if (lane_load)
        begin
            s2_done_reg <= s1_done_reg;
            s2_row_reg  <= s1_row_reg;
            s2_col_reg  <= s1_col_reg;
        end
        if (s3_en && s2_valid_reg)
        begin
            res_px_reg   <= quot;
            res_done_reg <= s2_done_reg;
            res_row_reg  <= s2_row_reg;
            res_col_reg  <= s2_col_reg;
        end
    end

    assign result.valid      = res_valid_reg;
    assign result.red_out    = res_px_reg.red;
    assign result.green_out  = res_px_reg.green;
    assign result.blue_out   = res_px_reg.blue;
    assign result.out_row    = res_row_reg;
    assign result.out_col    = res_col_reg;
    assign result.frame_done = res_done_reg;

endmodule

`default_nettype wire

/* sim/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;
    import rcb_pkg::*;

    localparam int SETTLE_CYCLES  = 10;
    localparam int CYCLE_LIMIT    = 1_000_000;
    localparam int RANDOM_PIXELS  = 760;
    localparam int SQUEEZE_CYCLES = 400;
    localparam int SQUEEZE_AT     = 200;
    localparam int PAUSE_AT       = 500;
    localparam int MAX_GAP        = 16;

    localparam rgb_t WHITE_PX = 24'hFFFFFF;
    localparam rgb_t BLACK_PX = 24'h000000;
    localparam rgb_t RED_PX   = 24'h0000FF;
    localparam rgb_t GREEN_PX = 24'h00FF00;
    localparam rgb_t BLUE_PX  = 24'hFF0000;

    typedef struct packed {
        rgb_t             color;
        logic [ROW_W-1:0] row;
        logic [COL_W-1:0] col;
        logic             done;
    } blur_word_t;

    typedef enum logic {STEP_PIXEL, STEP_WRITE} step_kind_t;

    typedef struct {
        step_kind_t       kind;
        cfg_reg_t         reg_idx;
        logic [CFG_W-1:0] value;
        rgb_t             px;
        bit               typed;
        blur_word_t       want;
    } step_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_wr_en;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    rcb_pix_if pix_if ();
    rcb_res_if res_if ();

    step_t        steps [$];
    blur_word_t   exp_q [$];

    int           cycle_count;
    int           sent_count;
    int           rcv_count;
    int           write_count;
    int           drv_errors;
    int           mon_errors;
    bit           squeeze_req;
    bit           squeeze_done;

    // predictor state
    int unsigned  m_width;
    int unsigned  m_height;
    int unsigned  m_col;
    int unsigned  m_row;
    rgb_t         m_two_up [MAX_WIDTH];
    rgb_t         m_one_up [MAX_WIDTH];
    rgb_t         m_win [6];

    rgb_3x3_cross_blur DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .pixel     (pix_if),
        .result    (res_if),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void model_reset();
        m_width  = 640;
        m_height = 480;
        m_col    = 0;
        m_row    = 0;
        foreach (m_two_up[i])
        begin
            m_two_up[i] = '0;
            m_one_up[i] = '0;
        end
        foreach (m_win[i])
            m_win[i] = '0;
    endfunction

    function automatic void model_config(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        unique case (idx)
            REG_IMAGE_WIDTH:  m_width  = val;
            REG_IMAGE_HEIGHT: m_height = val;
        endcase
    endfunction

    function automatic rgb_t blur(input rgb_t c, input rgb_t u, input rgb_t d,
                                  input rgb_t l, input rgb_t r);
        rgb_t        res;
        int unsigned s;
        res = '0;
        for (int k = 0; k < NUM_CHAN; k++)
        begin
            s = 5 * c[k*CHAN_W +: CHAN_W] + u[k*CHAN_W +: CHAN_W] + d[k*CHAN_W +: CHAN_W]
              + l[k*CHAN_W +: CHAN_W] + r[k*CHAN_W +: CHAN_W];
            res[k*CHAN_W +: CHAN_W] = CHAN_W'(s / 9);
        end
        return res;
    endfunction

    function automatic void model_step(input rgb_t px, output bit emit,
                                       output blur_word_t word);
        int unsigned       w;
        int unsigned       h;
        int unsigned       c;
        int unsigned       r;
        logic [ADDR_W-1:0] idx;
        rgb_t              above2;
        rgb_t              above1;
        rgb_t              res;
        bit                last_col;
        bit                last_row;
        w = m_width;
        h = m_height;
        c = m_col;
        r = m_row;
        if (w < 3)
            w = 3;
        if (w > MAX_WIDTH)
            w = MAX_WIDTH;
        if (h < 3)
            h = 3;
        idx      = ADDR_W'(c);
        above2   = m_two_up[idx];
        above1   = m_one_up[idx];
        last_col = (c + 1 >= w);
        last_row = (r + 1 >= h);
        emit     = (r >= 2) && (c >= 2);
        res      = '0;
        if (emit)
            res = blur(m_win[1], m_win[0], m_win[2], m_win[4], above1);
        m_win[3] = m_win[0];
        m_win[4] = m_win[1];
        m_win[5] = m_win[2];
        m_win[0] = above2;
        m_win[1] = above1;
        m_win[2] = px;
        m_two_up[idx] = above1;
        m_one_up[idx] = px;
        if (last_col)
        begin
            m_col = 0;
            m_row = last_row ? 0 : ((r + 1) & 32'hFFF);
        end
        else
        begin
            m_col = (c + 1) & 32'h7FF;
        end
        word.color = res;
        word.row   = ROW_W'(r - 1);
        word.col   = COL_W'(c - 1);
        word.done  = last_col && last_row;
    endfunction

    // the single inner pixel of a 3x3 frame
    function automatic blur_word_t first_center(input rgb_t color);
        return '{color: color, row: ROW_W'(1), col: COL_W'(1), done: 1'b1};
    endfunction

    function automatic void add_write(input cfg_reg_t idx, input int unsigned val);
        step_t st;
        st = '{kind: STEP_WRITE, reg_idx: idx, value: CFG_W'(val), px: '0,
               typed: 1'b0, want: '0};
        steps.push_back(st);
    endfunction

    function automatic void add_pixel(input rgb_t px);
        step_t st;
        st = '{kind: STEP_PIXEL, reg_idx: REG_IMAGE_WIDTH, value: '0, px: px,
               typed: 1'b0, want: '0};
        steps.push_back(st);
    endfunction

    function automatic void add_typed(input rgb_t px, input blur_word_t want);
        step_t st;
        st = '{kind: STEP_PIXEL, reg_idx: REG_IMAGE_WIDTH, value: '0, px: px,
               typed: 1'b1, want: want};
        steps.push_back(st);
    endfunction

    function automatic void build_table();
        int n;
        // smallest frame, all white then all black
        add_write(REG_IMAGE_WIDTH, 3);
        add_write(REG_IMAGE_HEIGHT, 3);
        for (n = 0; n < 8; n++)
            add_pixel(WHITE_PX);
        add_typed(WHITE_PX, first_center(WHITE_PX));
        for (n = 0; n < 8; n++)
            add_pixel(BLACK_PX);
        add_typed(BLACK_PX, first_center(BLACK_PX));
        // lone white center
        for (n = 0; n < 9; n++)
            add_pixel((n == 4) ? WHITE_PX : BLACK_PX);
        // 5x4 color pattern
        add_write(REG_IMAGE_WIDTH, 5);
        add_write(REG_IMAGE_HEIGHT, 4);
        for (n = 0; n < 20; n++)
            add_pixel((n % 4 == 0) ? WHITE_PX : (n % 4 == 1) ? RED_PX :
                      (n % 4 == 2) ? GREEN_PX : BLUE_PX);
        // sizes below the minimum saturate to 3
        add_write(REG_IMAGE_WIDTH, 0);
        add_write(REG_IMAGE_HEIGHT, 1);
        for (n = 0; n < 8; n++)
            add_pixel(WHITE_PX);
        add_typed(WHITE_PX, first_center(WHITE_PX));
        // width above the maximum, then shrunk inside the first row
        add_write(REG_IMAGE_WIDTH, 4095);
        add_write(REG_IMAGE_HEIGHT, 3);
        for (n = 0; n < 5; n++)
            add_pixel(24'(n * 32'h0012_3457));
        add_write(REG_IMAGE_WIDTH, 4);
        for (n = 0; n < 9; n++)
            add_pixel(24'(n * 32'h0031_7A29 + 32'h0000_5A5A));
        // height shrunk after three rows ends the frame early
        add_write(REG_IMAGE_WIDTH, 4);
        add_write(REG_IMAGE_HEIGHT, 10);
        for (n = 0; n < 12; n++)
            add_pixel(24'(n * 32'h0047_1C83 + 32'h0010_2030));
        add_write(REG_IMAGE_HEIGHT, 2);
        for (n = 0; n < 4; n++)
            add_pixel(24'(n * 32'h0055_AA11 + 32'h00F0_0F0F));
    endfunction

    // wait until every expected word has come and the pipe is empty
    task automatic drain();
        pix_if.valid <= 1'b0;
        @(posedge clk);
        while (exp_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_W-1:0] val);
        drain();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        model_config(idx, val);
        write_count++;
    endtask

    task automatic send_pixel(input rgb_t px, input bit typed, input blur_word_t want);
        int         gap;
        bit         emit;
        blur_word_t pred;
        gap = $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            pix_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_if.valid    <= 1'b1;
        pix_if.red_in   <= px.red;
        pix_if.green_in <= px.green;
        pix_if.blue_in  <= px.blue;
        @(posedge clk);
        while (!pix_if.ready)
            @(posedge clk);
        model_step(px, emit, pred);
        if (typed && !emit)
        begin
            $error("typed row %0d completes no inner pixel", sent_count);
            drv_errors++;
        end
        if (emit)
            exp_q.push_back(typed ? want : pred);
        sent_count++;
    endtask

    initial
    begin : driver
        step_t st;
        rgb_t  px;
        rst_n           = 1'b0;
        cfg_wr_en       = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        pix_if.valid    = 1'b0;
        pix_if.red_in   = '0;
        pix_if.green_in = '0;
        pix_if.blue_in  = '0;
        sent_count      = 0;
        write_count     = 0;
        drv_errors      = 0;
        squeeze_req     = 1'b0;
        model_reset();
        build_table();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (steps[n])
        begin
            st = steps[n];
            if (st.kind == STEP_WRITE)
                write_reg(st.reg_idx, st.value);
            else
                send_pixel(st.px, st.typed, st.want);
        end

        for (int i = 0; i < RANDOM_PIXELS; i++)
        begin
            // new frame sizes only at a frame boundary
            if (m_col == 0 && m_row == 0 && (i == 0 || $urandom_range(0, 3) == 0))
            begin
                write_reg(REG_IMAGE_WIDTH, CFG_W'($urandom_range(3, 8)));
                write_reg(REG_IMAGE_HEIGHT, CFG_W'($urandom_range(3, 6)));
            end
            if (i == SQUEEZE_AT)
                squeeze_req = 1'b1;
            if (i == PAUSE_AT)
                drain();
            px = 24'($urandom());
            if ($urandom_range(0, 7) == 0)
                px = ($urandom_range(0, 1) == 0) ? WHITE_PX : BLACK_PX;
            send_pixel(px, 1'b0, '0);
        end

        drain();
        while (!squeeze_done)
            @(posedge clk);

        $display("Run covered %0d pixels, %0d result words and %0d register writes,",
                 sent_count, rcv_count, write_count);
        $display("with saturated and mid-frame sizes, a long output stall and a full drain.");
        if (drv_errors == 0 && mon_errors == 0 && exp_q.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin : receiver
        int         gap;
        int         hold;
        blur_word_t want;
        rcv_count    = 0;
        mon_errors   = 0;
        squeeze_done = 1'b0;
        res_if.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            hold = (squeeze_req && !squeeze_done) ? SQUEEZE_CYCLES : 0;
            gap  = $urandom_range(0, MAX_GAP);
            if (hold + gap > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (hold + gap) @(posedge clk);
            end
            if (hold > 0)
                squeeze_done = 1'b1;
            res_if.ready <= 1'b1;
            @(posedge clk);
            while (!res_if.valid)
                @(posedge clk);
            if (exp_q.size() == 0)
            begin
                $error("unexpected result word at row %0d col %0d",
                       res_if.out_row, res_if.out_col);
                mon_errors++;
            end
            else
            begin
                want = exp_q.pop_front();
                if (res_if.red_out !== want.color.red)
                begin
                    $error("red_out mismatch: expected %0d, actual %0d",
                           want.color.red, res_if.red_out);
                    mon_errors++;
                end
                if (res_if.green_out !== want.color.green)
                begin
                    $error("green_out mismatch: expected %0d, actual %0d",
                           want.color.green, res_if.green_out);
                    mon_errors++;
                end
                if (res_if.blue_out !== want.color.blue)
                begin
                    $error("blue_out mismatch: expected %0d, actual %0d",
                           want.color.blue, res_if.blue_out);
                    mon_errors++;
                end
                if (res_if.out_row !== want.row)
                begin
                    $error("out_row mismatch: expected %0d, actual %0d",
                           want.row, res_if.out_row);
                    mon_errors++;
                end
                if (res_if.out_col !== want.col)
                begin
                    $error("out_col mismatch: expected %0d, actual %0d",
                           want.col, res_if.out_col);
                    mon_errors++;
                end
                if (res_if.frame_done !== want.done)
                begin
                    $error("frame_done mismatch: expected %0d, actual %0d",
                           want.done, res_if.frame_done);
                    mon_errors++;
                end
            end
            rcv_count++;
        end
    end

    initial
    begin : watchdog
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count >= CYCLE_LIMIT)
            begin
                $error("cycle limit of %0d reached", CYCLE_LIMIT);
                $display("Verification failed");
                $finish;
            end
        end
    end

endmodule
